// ===== sv/wsfp_pkg.sv =====
// Shared types and constants for the WebSocket frame parser.
// No dependencies; imported by every module of the parser.
package wsfp_pkg;

    localparam int DEF_REMAINING_COUNT_BITS = 21;
    localparam int CFG_LEN_W                = 21;
    localparam logic [CFG_LEN_W-1:0] MAX_LEN_RESET = CFG_LEN_W'(1024 * 1024);

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       connection_start;
    } rx_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] payload_byte;
        logic [3:0] frame_opcode;
        logic       last_of_frame;
    } result_t;

endpackage

// ===== sv/wsfp_in_reg.sv =====
// Input register stage of the WebSocket frame parser.
// Depends on wsfp_pkg for the received item type.
module wsfp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wsfp_pkg::rx_item_t in_item,
    output logic              held_valid,
    output wsfp_pkg::rx_item_t held_item,
    input  logic              advance
);
    import wsfp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== sv/wsfp_core.sv =====
// Frame header decode, length check and payload unmasking, one byte per step.
// Depends on wsfp_pkg for item/result types and result kind codes.
module wsfp_core #(
    parameter int REMAINING_COUNT_BITS = wsfp_pkg::DEF_REMAINING_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  wsfp_pkg::rx_item_t                  item,
    input  logic [wsfp_pkg::CFG_LEN_W-1:0]      max_len,
    output logic                                res_valid,
    output wsfp_pkg::result_t                   res
);
    import wsfp_pkg::*;

    localparam int RCB   = REMAINING_COUNT_BITS;
    localparam int LIM_W = (RCB > CFG_LEN_W) ? RCB : CFG_LEN_W;
    localparam logic [LIM_W-1:0] COUNT_MASK = LIM_W'({RCB{1'b1}});

    localparam logic [2:0] PH_HDR0   = 3'd0;
    localparam logic [2:0] PH_HDR1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_KEY    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_DROP   = 3'd5;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    logic [2:0]     phase_reg,  phase_next,  cur_phase;
    logic [3:0]     opcode_reg, opcode_next, cur_opcode;
    logic           mask_reg,   mask_next,   cur_mask;
    // extended length: low RCB bits plus a sticky flag for any bit shifted above them
    logic [RCB-1:0] acc_reg,    acc_next,    cur_acc;
    logic           high_reg,   high_next,   cur_high;
    logic [3:0]     count_reg,  count_next,  cur_count;
    logic [31:0]    key_reg,    key_next,    cur_key;
    logic [1:0]     pos_reg,    pos_next,    cur_pos;
    logic [RCB-1:0] rem_reg,    rem_next,    cur_rem;

    logic [7:0]       b;
    logic [RCB+7:0]   shifted;
    logic             len_done;
    logic [LIM_W-1:0] len_val;
    logic             len_high;
    logic [LIM_W-1:0] cfg_ext;
    logic [LIM_W-1:0] limit_eff;
    logic [7:0]       key_byte;

    assign b         = item.data_byte;
    assign cfg_ext   = LIM_W'(max_len);
    assign limit_eff = (cfg_ext > COUNT_MASK) ? COUNT_MASK : cfg_ext;
    assign shifted   = {cur_acc, b};

    // connection_start restarts the parser before this byte is taken
    always_comb
    begin
        if (item.connection_start)
        begin
            cur_phase  = PH_HDR0;
            cur_opcode = '0;
            cur_mask   = 1'b0;
            cur_acc    = '0;
            cur_high   = 1'b0;
            cur_count  = '0;
            cur_key    = '0;
            cur_pos    = '0;
            cur_rem    = '0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_opcode = opcode_reg;
            cur_mask   = mask_reg;
            cur_acc    = acc_reg;
            cur_high   = high_reg;
            cur_count  = count_reg;
            cur_key    = key_reg;
            cur_pos    = pos_reg;
            cur_rem    = rem_reg;
        end
    end

    always_comb
    begin
        case (cur_pos)
            2'd0:    key_byte = cur_key[31:24];
            2'd1:    key_byte = cur_key[23:16];
            2'd2:    key_byte = cur_key[15:8];
            default: key_byte = cur_key[7:0];
        endcase
    end

    always_comb
    begin
        phase_next  = cur_phase;
        opcode_next = cur_opcode;
        mask_next   = cur_mask;
        acc_next    = cur_acc;
        high_next   = cur_high;
        count_next  = cur_count;
        key_next    = cur_key;
        pos_next    = cur_pos;
        rem_next    = cur_rem;
        len_done    = 1'b0;
        len_val     = '0;
        len_high    = 1'b0;
        res_valid   = 1'b0;
        res.result_kind   = KIND_DATA;
        res.payload_byte  = '0;
        res.frame_opcode  = cur_opcode;
        res.last_of_frame = 1'b0;

        case (cur_phase)
            PH_HDR0:
            begin
                opcode_next = b[3:0];
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                mask_next = b[7];
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64)
                begin
                    acc_next   = '0;
                    high_next  = 1'b0;
                    count_next = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
                    phase_next = PH_EXTLEN;
                end
                else
                begin
                    len_done = 1'b1;
                    len_val  = LIM_W'(b[6:0]);
                end
            end
            PH_EXTLEN:
            begin
                acc_next   = shifted[RCB-1:0];
                high_next  = cur_high || (shifted[RCB+7:RCB] != 8'd0);
                count_next = cur_count - 4'd1;
                if (count_next == 4'd0)
                begin
                    len_done = 1'b1;
                    len_val  = LIM_W'(acc_next);
                    len_high = high_next;
                end
            end
            PH_KEY:
            begin
                key_next   = {cur_key[23:0], b};
                count_next = cur_count - 4'd1;
                if (count_next == 4'd0)
                begin
                    if (cur_rem == '0)
                    begin
                        phase_next        = PH_HDR0;
                        res_valid         = 1'b1;
                        res.result_kind   = KIND_EMPTY;
                        res.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                pos_next          = cur_pos + 2'd1;
                rem_next          = cur_rem - RCB'(1);
                res_valid         = 1'b1;
                res.result_kind   = KIND_DATA;
                res.payload_byte  = cur_mask ? (b ^ key_byte) : b;
                res.last_of_frame = (rem_next == '0);
                if (rem_next == '0)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                // dropping until the next connection start
            end
        endcase

        if (len_done)
        begin
            if (len_high || len_val > limit_eff)
            begin
                phase_next      = PH_DROP;
                res_valid       = 1'b1;
                res.result_kind = KIND_ERROR;
            end
            else
            begin
                rem_next = len_val[RCB-1:0];
                pos_next = '0;
                if (mask_next)
                begin
                    key_next   = '0;
                    count_next = 4'd4;
                    phase_next = PH_KEY;
                end
                else if (rem_next == '0)
                begin
                    phase_next        = PH_HDR0;
                    res_valid         = 1'b1;
                    res.result_kind   = KIND_EMPTY;
                    res.last_of_frame = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            mask_reg   <= 1'b0;
            acc_reg    <= '0;
            high_reg   <= 1'b0;
            count_reg  <= '0;
            key_reg    <= '0;
            pos_reg    <= '0;
            rem_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            mask_reg   <= mask_next;
            acc_reg    <= acc_next;
            high_reg   <= high_next;
            count_reg  <= count_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            rem_reg    <= rem_next;
        end
    end

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.result_kind == KIND_ERROR
            |-> !res.last_of_frame && res.payload_byte == 8'd0)
        else $error("error result carries payload or last flag");

    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_DROP && !item.connection_start |-> !res_valid)
        else $error("result produced while dropping");

    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> rem_reg != '0)
        else $error("payload phase with no bytes remaining");

    a_final_byte: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item.connection_start && phase_reg == PH_DATA && rem_reg == RCB'(1)
            |=> phase_reg == PH_HDR0 && $past(res_valid) && $past(res.last_of_frame))
        else $error("final payload byte not marked or phase not returned to header");

endmodule

// ===== sv/wsfp_out_reg.sv =====
// Result register of the WebSocket frame parser; holds one result until taken.
// Depends on wsfp_pkg for the result type.
module wsfp_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic              load_valid,
    input  wsfp_pkg::result_t load_res,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output wsfp_pkg::result_t out_res
);
    import wsfp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = load_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && load_valid)
        begin
            res_reg <= load_res;
        end
    end

endmodule

// ===== sv/websocket_frame_parser.sv =====
// Top level of the WebSocket frame parser (receive side, RFC 6455 framing).
// Depends on wsfp_pkg, wsfp_in_reg, wsfp_core and wsfp_out_reg.
//
// Usage:
//   s_axis_*  carries the received byte stream, one byte per transaction;
//             tuser set restarts the parser at the frame header before the byte.
//   m_axis_*  carries at most one result per input byte: an unmasked payload
//             byte, an empty-frame marker or an oversize-length error (tuser).
//             tlast marks the final payload byte and the empty-frame marker.
//   cfg_*     writes max_payload_len; write it only while the parser is idle.
// Throughput is one byte per clock while m_axis_tready is high: the
// header/length/unmask step is one pass of logic between the input register
// and the result register. Header and key bytes give no result, but the byte
// ending the length or the key may give an error or empty-frame marker; bytes
// dropped after an error give none. Reset clears both stages, returns the
// parser to the first header byte and sets max_payload_len to 1048576. When
// m_axis_tready is low the result register holds; one more byte is taken into
// the input register, then s_axis_tready drops until the result is taken.
module websocket_frame_parser #(
    parameter int REMAINING_COUNT_BITS = wsfp_pkg::DEF_REMAINING_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                     s_axis_tuser,   // [0] connection_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [15:0]                    m_axis_tdata,   // [7:0] payload_byte,
                                                           // [11:8] frame_opcode
    output logic [1:0]                     m_axis_tuser,   // [1:0] result_kind
    output logic                           m_axis_tlast,   // last_of_frame
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wsfp_pkg::CFG_LEN_W-1:0] cfg_data        // max_payload_len
);
    import wsfp_pkg::*;

    logic [CFG_LEN_W-1:0] max_len_reg;
    logic [CFG_LEN_W-1:0] max_len_next;

    rx_item_t in_item;
    rx_item_t held_item;
    logic     held_valid;
    logic     advance;
    logic     can_load;
    logic     res_valid;
    result_t  res;
    result_t  out_res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        max_len_next = max_len_reg;
        if (cfg_valid && cfg_ready)
        begin
            max_len_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else
        begin
            max_len_reg <= max_len_next;
        end
    end

    assign in_item.data_byte        = s_axis_tdata;
    assign in_item.connection_start = s_axis_tuser[0];

    assign advance = held_valid && can_load;

    wsfp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .held_valid (held_valid),
        .held_item  (held_item),
        .advance    (advance)
    );

    wsfp_core #(
        .REMAINING_COUNT_BITS (REMAINING_COUNT_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (held_item),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_valid (res_valid),
        .load_res   (res),
        .can_load   (can_load),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (out_res)
    );

    assign m_axis_tdata = {4'd0, out_res.frame_opcode, out_res.payload_byte};
    assign m_axis_tuser = out_res.result_kind;
    assign m_axis_tlast = out_res.last_of_frame;

endmodule
